/* hw/rtl/qds_pkg.sv */
// qds_pkg: shared types, constants and the direction table for the
// quadrature detent selector. No dependencies; imported by every rtl file.

package qds_pkg;

  // field widths
  localparam int OPTION_W = 8;
  localparam int COUNT_W  = 11;
  localparam int QSTEP_W  = 12;
  localparam int PICK_W   = 10;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPTION_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTION_MAX = 8'd1;

  // configuration reset values
  localparam logic [OPTION_W-1:0] OPTION_MIN_RST = 8'd0;
  localparam logic [OPTION_W-1:0] OPTION_MAX_RST = 8'd3;

  // previous/current phase pairs that count upwards
  localparam logic [3:0] PAIR_UP_3_TO_1 = 4'hD;
  localparam logic [3:0] PAIR_UP_1_TO_0 = 4'h4;
  localparam logic [3:0] PAIR_UP_0_TO_2 = 4'h2;
  localparam logic [3:0] PAIR_UP_2_TO_3 = 4'hB;

  typedef logic [1:0]                 phase_t;
  typedef logic [OPTION_W-1:0]        option_t;
  typedef logic signed [COUNT_W-1:0]  count_t;
  typedef logic signed [QSTEP_W-1:0]  qstep_t;
  typedef logic signed [PICK_W-1:0]   pick_t;

  typedef struct packed {
    phase_t  prev_phase;
    count_t  step_count;
    option_t current_option;
  } qds_state_t;

  typedef struct packed {
    option_t option_min;
    option_t option_max;
  } qds_cfg_t;

  typedef struct packed {
    option_t selected_option;
    logic    option_changed;
    qstep_t  quarter_steps;
  } qds_result_t;

  // 1 when the transition prev -> now is a forward quarter step
  function automatic logic step_is_up(phase_t prev, phase_t now);
    logic up;
    unique case ({prev, now})
      PAIR_UP_3_TO_1,
      PAIR_UP_1_TO_0,
      PAIR_UP_0_TO_2,
      PAIR_UP_2_TO_3: up = 1'b1;
      default:        up = 1'b0;
    endcase
    return up;
  endfunction

endpackage

/* hw/rtl/qds_if.sv */
// qds_if: valid/ready channel interfaces for the quadrature detent selector
// (sample input, result output, configuration write). Depends on qds_pkg.

interface qds_in_if
  import qds_pkg::*;
();
  logic valid;
  logic ready;
  logic phase_a;
  logic phase_b;

  modport source (output valid, output phase_a, output phase_b, input ready);
  modport sink   (input valid, input phase_a, input phase_b, output ready);
endinterface

interface qds_out_if
  import qds_pkg::*;
();
  logic    valid;
  logic    ready;
  option_t selected_option;
  logic    option_changed;
  qstep_t  quarter_steps;

  modport source (output valid, output selected_option, output option_changed,
                  output quarter_steps, input ready);
  modport sink   (input valid, input selected_option, input option_changed,
                  input quarter_steps, output ready);
endinterface

interface qds_cfg_if
  import qds_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/qds_cfg_regs.sv */
// qds_cfg_regs: option_min / option_max configuration registers.
// Depends on qds_pkg and qds_cfg_if.

module qds_cfg_regs
  import qds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qds_cfg_if.sink   cfg_ch,
  output qds_cfg_t  cfg
);

  option_t option_min_r;
  option_t option_max_r;

  // always ready, writes take effect at the handshake
  assign cfg_ch.ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      option_min_r <= OPTION_MIN_RST;
      option_max_r <= OPTION_MAX_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_OPTION_MIN) begin
        option_min_r <= cfg_ch.data;
      end
      if (cfg_ch.index == CFG_OPTION_MAX) begin
        option_max_r <= cfg_ch.data;
      end
    end
  end

  assign cfg.option_min = option_min_r;
  assign cfg.option_max = option_max_r;

endmodule

/* hw/rtl/qds_step.sv */
// qds_step: combinational decode of one sample against the held state:
// quarter-step counting, option selection and wrap. Depends on qds_pkg.

module qds_step
  import qds_pkg::*;
(
  input  qds_state_t  state,
  input  qds_cfg_t    cfg,
  input  phase_t      now,
  output qds_state_t  state_nxt,
  output qds_result_t result
);

  logic   moved;
  qstep_t count_ext;
  qstep_t count_step;
  qstep_t count_fin;
  pick_t  pick;
  pick_t  cur_ext;
  pick_t  min_ext;
  pick_t  max_ext;
  pick_t  opt_a;
  pick_t  opt_fin;
  logic   changed;

  // single-step transition only: not idle and not both bits flipped
  assign moved = (now != state.prev_phase) && (now != ~state.prev_phase);

  assign count_ext  = qstep_t'(state.step_count);
  assign count_step = step_is_up(state.prev_phase, now) ? count_ext + qstep_t'(1)
                                                        : count_ext - qstep_t'(1);
  assign pick    = count_step[QSTEP_W-1:2];
  assign cur_ext = pick_t'({2'b00, state.current_option});
  assign min_ext = pick_t'({2'b00, cfg.option_min});
  assign max_ext = pick_t'({2'b00, cfg.option_max});

  // detent selection with downward then upward wrap
  always_comb begin
    count_fin = count_ext;
    opt_fin   = cur_ext;
    opt_a     = cur_ext;
    changed   = 1'b0;
    if (moved) begin
      count_fin = count_step;
      if ((count_step[1:0] == 2'b00) && (pick != cur_ext)) begin
        changed = 1'b1;
        opt_a   = pick;
        if (pick < min_ext) begin
          opt_a     = max_ext;
          count_fin = qstep_t'({2'b00, cfg.option_max, 2'b00});
        end
        opt_fin = opt_a;
        if (opt_a > max_ext) begin
          opt_fin   = min_ext;
          count_fin = qstep_t'({2'b00, cfg.option_min, 2'b00});
        end
      end
    end
  end

  assign state_nxt.prev_phase     = moved ? now : state.prev_phase;
  assign state_nxt.step_count     = count_fin[COUNT_W-1:0];
  assign state_nxt.current_option = opt_fin[OPTION_W-1:0];

  assign result.selected_option = opt_fin[OPTION_W-1:0];
  assign result.option_changed  = changed;
  assign result.quarter_steps   = count_fin;

endmodule

/* hw/rtl/quadrature_detent_selector.sv */
// quadrature_detent_selector: top level, x4 quadrature decoder driving a
// wrapping option selector. Depends on qds_pkg, qds_if, qds_cfg_regs, qds_step.
//
//   channel  dir  payload                                         handshake
//   in_ch    in   phase_a, phase_b                                valid/ready
//   out_ch   out  selected_option, option_changed, quarter_steps  valid/ready
//   cfg_ch   in   index (0 option_min, 1 option_max), data        valid/ready
//
// One sample per cycle sustained while out_ch is ready; from input transaction
// to result: sample register, then decode into the result register.
// The decoder state is updated as the sample moves into the result register.
// rst_n is synchronous: clears decoder state, bound registers, and both stage valids.
// A stalled result holds; the sample stage still takes a new transaction
// in the cycle the result is taken. cfg_ch is always ready.

module quadrature_detent_selector
  import qds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  qds_in_if.sink    in_ch,
  qds_out_if.source out_ch,
  qds_cfg_if.sink   cfg_ch
);

  logic        in_vld_r;
  phase_t      sample_r;
  logic        out_vld_r;
  qds_result_t result_r;
  qds_state_t  state_r;
  qds_state_t  state_nxt;
  qds_result_t result_nxt;
  qds_cfg_t    cfg;
  logic        advance;

  qds_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  qds_step u_step (
    .state     (state_r),
    .cfg       (cfg),
    .now       (sample_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // sample moves on when the result register is free or being emptied
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= {in_ch.phase_a, in_ch.phase_b};
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.selected_option = result_r.selected_option;
  assign out_ch.option_changed  = result_r.option_changed;
  assign out_ch.quarter_steps   = result_r.quarter_steps;

endmodule

/* bench/tb_quadrature_detent_selector.sv */
// tb_quadrature_detent_selector: self-checking bench for the x4 quadrature detent selector.
// Uses qds_pkg and the channel interfaces in qds_if. Stimulus is a directed table, then
// random encoder walks; checks use a cycle-free decoder model, or typed table values.

module tb_quadrature_detent_selector;
  import qds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;
  localparam int N_PROBES    = 25;
  localparam int N_PHASES    = 8;

  typedef struct {
    phase_t      ph;
    bit          typed;
    qds_result_t want;
  } probe_t;

  typedef struct {
    option_t lo;
    option_t hi;
    int      items;
    int      up_pct;
  } phase_plan_t;

  logic clk;
  logic rst_n;

  qds_in_if  in_ch ();
  qds_out_if out_ch ();
  qds_cfg_if cfg_ch ();

  quadrature_detent_selector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // decoder model state
  phase_t  last_phase;
  int      qcount;
  int      held_option;
  option_t opt_lo;
  option_t opt_hi;

  qds_result_t pending[$];

  int  errors = 0;
  int  n_samples;
  int  n_changes;
  int  n_wraps;
  int  n_cfg_writes;
  int  quiet = 0;
  int  in_idle_pct;
  int  out_idle_pct;
  bit  holding;

  // directed walk from reset: unchanged, all four double steps, detents and both wraps
  probe_t directed_probes [N_PROBES] = '{
    '{2'd0, 1'b1, {8'd0, 1'b0, 12'd0}},
    '{2'd3, 1'b1, {8'd0, 1'b0, 12'd0}},
    '{2'd2, 1'b0, '0},
    '{2'd3, 1'b0, '0},
    '{2'd1, 1'b0, '0},
    '{2'd0, 1'b1, {8'd1, 1'b1, 12'd4}},
    '{2'd1, 1'b0, '0},
    '{2'd2, 1'b1, {8'd1, 1'b0, 12'd3}},
    '{2'd0, 1'b0, '0},
    '{2'd1, 1'b0, '0},
    '{2'd3, 1'b0, '0},
    '{2'd2, 1'b0, '0},
    '{2'd0, 1'b1, {8'd0, 1'b1, 12'd0}},
    '{2'd1, 1'b1, {8'd0, 1'b0, 12'hFFF}},
    '{2'd3, 1'b0, '0},
    '{2'd2, 1'b0, '0},
    '{2'd0, 1'b1, {8'd3, 1'b1, 12'd12}},
    '{2'd2, 1'b0, '0},
    '{2'd3, 1'b0, '0},
    '{2'd1, 1'b0, '0},
    '{2'd0, 1'b1, {8'd0, 1'b1, 12'd0}},
    '{2'd2, 1'b0, '0},
    '{2'd1, 1'b1, {8'd0, 1'b0, 12'd1}},
    '{2'd3, 1'b0, '0},
    '{2'd0, 1'b1, {8'd0, 1'b0, 12'd2}}
  };

  // bound settings per random phase, extremes and misordered bounds included
  phase_plan_t phase_plans [N_PHASES] = '{
    '{8'd255, 8'd255, 176, 50},
    '{8'd0,   8'd255, 176, 50},
    '{8'd200, 8'd100, 176, 50},
    '{8'd0,   8'd0,   176, 50},
    '{8'd10,  8'd12,  176, 60},
    '{8'd255, 8'd0,   176, 50},
    '{8'd0,   8'd255, 176, 70},
    '{8'd0,   8'd3,   176, 40}
  };

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // next phase code for a forward or backward quarter step
  function automatic phase_t step_fwd(phase_t p);
    case (p)
      2'd0:    return 2'd2;
      2'd2:    return 2'd3;
      2'd3:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic phase_t step_back(phase_t p);
    case (p)
      2'd0:    return 2'd1;
      2'd1:    return 2'd3;
      2'd3:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // advance the decoder model by one sample and return the result it gives
  function automatic qds_result_t advance_decoder(phase_t now);
    qds_result_t r;
    int pick;
    r = '0;
    // double steps flip both bits and leave the old phase in place
    if (now != last_phase && (now ^ last_phase) != 2'b11) begin
      case ({last_phase, now})
        PAIR_UP_3_TO_1, PAIR_UP_1_TO_0, PAIR_UP_0_TO_2, PAIR_UP_2_TO_3: qcount++;
        default: qcount--;
      endcase
      if (qcount % 4 == 0) begin
        pick = qcount / 4;
        if (pick != held_option) begin
          held_option      = pick;
          r.option_changed = 1'b1;
          n_changes++;
          // lower check first, so misordered bounds can end on opt_lo
          if (held_option < int'(opt_lo)) begin
            held_option = int'(opt_hi);
            qcount      = int'(opt_hi) * 4;
            n_wraps++;
          end
          if (held_option > int'(opt_hi)) begin
            held_option = int'(opt_lo);
            qcount      = int'(opt_lo) * 4;
            n_wraps++;
          end
        end
      end
      last_phase = now;
    end
    r.selected_option = option_t'(held_option);
    r.quarter_steps   = qstep_t'(qcount);
    return r;
  endfunction

  // offer one sample, wait for the transaction, queue its expected result
  task automatic send_sample(input phase_t ph, input bit typed, input qds_result_t want);
    qds_result_t got;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.phase_a <= ph[1];
    in_ch.phase_b <= ph[0];
    do @(posedge clk); while (!in_ch.ready);
    got = advance_decoder(ph);
    pending.push_back(typed ? want : got);
    n_samples++;
  endtask

  // stop offering and wait until every queued result has been taken
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // write both bounds back to back, valid held high between the two transactions
  task automatic write_bounds(input option_t lo, input option_t hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_OPTION_MIN;
    cfg_ch.data  <= lo;
    do @(posedge clk); while (!cfg_ch.ready);
    opt_lo = lo;
    cfg_ch.index <= CFG_OPTION_MAX;
    cfg_ch.data  <= hi;
    do @(posedge clk); while (!cfg_ch.ready);
    opt_hi = hi;
    cfg_ch.valid <= 1'b0;
    n_cfg_writes += 2;
  endtask

  // mostly clean encoder runs with random length and direction, plus some noise
  task automatic run_walk(input int count, input int up_pct);
    int     sent;
    int     kind;
    int     len;
    bit     up;
    phase_t nxt;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        up  = ($urandom_range(99) < up_pct);
        len = ($urandom_range(7) == 0) ? $urandom_range(48, 16) : $urandom_range(10, 1);
        repeat (len) begin
          nxt = up ? step_fwd(last_phase) : step_back(last_phase);
          send_sample(nxt, 1'b0, '0);
          sent++;
        end
      end else if (kind < 85) begin
        send_sample(last_phase, 1'b0, '0);
        sent++;
      end else if (kind < 93) begin
        send_sample(last_phase ^ 2'b11, 1'b0, '0);
        sent++;
      end else begin
        send_sample(phase_t'($urandom_range(3)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // long receiver hold-off so the pipeline fills and backs up the input
  task automatic hold_results(input int cycles);
    holding <= 1'b1;
    repeat (cycles) @(posedge clk);
    holding <= 1'b0;
  endtask

  // result receiver
  always @(posedge clk) begin
    out_ch.ready <= !holding && ($urandom_range(99) >= out_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    qds_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        $error("result transaction with nothing pending");
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (out_ch.selected_option !== exp_r.selected_option) begin
          $error("selected_option: expected %0d, got %0d",
                 exp_r.selected_option, out_ch.selected_option);
          errors++;
        end
        if (out_ch.option_changed !== exp_r.option_changed) begin
          $error("option_changed: expected %0d, got %0d",
                 exp_r.option_changed, out_ch.option_changed);
          errors++;
        end
        if (out_ch.quarter_steps !== exp_r.quarter_steps) begin
          $error("quarter_steps: expected %0d, got %0d",
                 exp_r.quarter_steps, out_ch.quarter_steps);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("FAILURE");
      $finish;
    end
  end

  // main sequence
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.phase_a = 1'b0;
    in_ch.phase_b = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_OPTION_MIN;
    cfg_ch.data   = '0;
    holding       = 1'b0;
    n_samples     = 0;
    n_changes     = 0;
    n_wraps       = 0;
    n_cfg_writes  = 0;
    last_phase    = 2'd0;
    qcount        = 0;
    held_option   = 0;
    opt_lo        = OPTION_MIN_RST;
    opt_hi        = OPTION_MAX_RST;
    in_idle_pct   = 33;
    out_idle_pct  = 48;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk under the reset bounds
    for (int i = 0; i < N_PROBES; i++)
      send_sample(directed_probes[i].ph, directed_probes[i].typed, directed_probes[i].want);
    settle();

    // random walks, one bound setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        in_idle_pct  = 33;
        out_idle_pct = 48;
      end else if (p < 6) begin
        in_idle_pct  = 48;
        out_idle_pct = 33;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_bounds(phase_plans[p].lo, phase_plans[p].hi);
      if (p == 6) begin
        fork
          hold_results(HOLD_CYCLES);
          run_walk(phase_plans[p].items, phase_plans[p].up_pct);
        join
      end else begin
        run_walk(phase_plans[p].items, phase_plans[p].up_pct);
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples over %0d bound settings, %0d register writes",
             n_samples, N_PHASES + 1, n_cfg_writes);
    $display("detent changes seen: %0d, of which wraps: %0d, mismatches: %0d",
             n_changes, n_wraps, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* quadrature_detent_selector.f */
hw/rtl/qds_pkg.sv
hw/rtl/qds_if.sv
hw/rtl/qds_cfg_regs.sv
hw/rtl/qds_step.sv
hw/rtl/quadrature_detent_selector.sv
bench/tb_quadrature_detent_selector.sv
